FILE: design/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, header layout, codes and interface structs of the
// first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

  localparam int HEAP_BYTES        = 16384;
  localparam int HEADER_BYTES      = 12;
  localparam int MIN_SPLIT_PAYLOAD = 8;
  localparam int REGION_MIN        = 64;
  localparam int REGION_RESET      = 4096;
  localparam int SIZE_ALIGN        = 8;

  localparam int OFF_W   = $clog2(HEAP_BYTES);
  localparam int SIZE_W  = OFF_W + 1;
  localparam int REQ_W   = 16;
  localparam int RSIZE_W = REQ_W + 1;
  localparam int CMP_W   = RSIZE_W + 1;

  localparam int WORD_BYTES = 4;
  localparam int MEM_DEPTH  = HEAP_BYTES / WORD_BYTES;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);

  typedef struct packed {
    logic              used;
    logic [OFF_W-1:0]  next;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_NULL  = 2'd1,
    STAT_NOFIT = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_A_CHK,
    S_A_WR,
    S_F_CHK,
    S_F_MRG,
    S_RES
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    hdr_t              wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    status_t          status;
    logic [OFF_W-1:0] offset;
  } result_t;

  // block offsets are word aligned
  function automatic logic [ADDR_W-1:0] addr_of(input logic [OFF_W-1:0] off);
    return off[OFF_W-1:OFF_W-ADDR_W];
  endfunction

endpackage

`default_nettype wire

FILE: design/ffha_hdr_mem.sv
// ----------------------------------------------------------------------------
// ffha_hdr_mem
// Header memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_hdr_mem (
  input  wire logic               clk,
  input  wire ffha_pkg::mem_req_t req,
  output ffha_pkg::hdr_t          rd_data
);

  ffha_pkg::hdr_t mem_r [ffha_pkg::MEM_DEPTH];
  ffha_pkg::hdr_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data_r <= mem_r[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: design/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// Chain walker: reads one header per cycle, decides fit, split, free and
// merge, writes headers back and produces one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [ffha_pkg::SIZE_W-1:0]   cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire ffha_pkg::op_t                 in_op,
  input  wire logic [ffha_pkg::REQ_W-1:0]    in_size,
  input  wire logic [ffha_pkg::OFF_W-1:0]    in_off,
  output ffha_pkg::mem_req_t                 mem_req,
  input  wire ffha_pkg::hdr_t                mem_rd,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output ffha_pkg::result_t                  res
);

  localparam int OFF_W  = ffha_pkg::OFF_W;
  localparam int SIZE_W = ffha_pkg::SIZE_W;
  localparam int RS_W   = ffha_pkg::RSIZE_W;
  localparam int CMP_W  = ffha_pkg::CMP_W;

  ffha_pkg::state_t  state_r, state_nxt;
  logic [SIZE_W-1:0] heap_r, heap_nxt;
  logic [OFF_W-1:0]  cur_r, cur_nxt;
  logic [OFF_W-1:0]  target_r, target_nxt;
  logic [RS_W-1:0]   rsize_r, rsize_nxt;
  ffha_pkg::hdr_t    hdr_r, hdr_nxt;
  ffha_pkg::result_t res_r, res_nxt;

  logic              fit;
  logic              split_ok;
  logic [CMP_W-1:0]  split_off;
  ffha_pkg::hdr_t    merged;
  logic [SIZE_W-1:0] clamped;

  always_comb begin
    fit = !mem_rd.used && (CMP_W'(mem_rd.size) >= CMP_W'(rsize_r));
    split_off = CMP_W'(cur_r) + CMP_W'(rsize_r) + CMP_W'(ffha_pkg::HEADER_BYTES);
    split_ok = (CMP_W'(mem_rd.size) >= CMP_W'(rsize_r)
                + CMP_W'(ffha_pkg::HEADER_BYTES + ffha_pkg::MIN_SPLIT_PAYLOAD))
               && (split_off < CMP_W'(ffha_pkg::HEAP_BYTES));
    merged.used = 1'b0;
    merged.next = mem_rd.next;
    merged.size = hdr_r.size + SIZE_W'(ffha_pkg::HEADER_BYTES) + mem_rd.size;
    priority if (cfg_wr_data < SIZE_W'(ffha_pkg::REGION_MIN)) begin
      clamped = SIZE_W'(ffha_pkg::REGION_MIN);
    end else if (cfg_wr_data > SIZE_W'(ffha_pkg::HEAP_BYTES)) begin
      clamped = SIZE_W'(ffha_pkg::HEAP_BYTES);
    end else begin
      clamped = cfg_wr_data;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    heap_nxt   = heap_r;
    cur_nxt    = cur_r;
    target_nxt = target_r;
    rsize_nxt  = rsize_r;
    hdr_nxt    = hdr_r;
    res_nxt    = res_r;
    mem_req    = '0;
    in_ready   = 1'b0;
    res_valid  = 1'b0;

    unique case (state_r)
      ffha_pkg::S_INIT: begin
        mem_req.we         = 1'b1;
        mem_req.waddr      = '0;
        mem_req.wdata.used = 1'b0;
        mem_req.wdata.next = '0;
        mem_req.wdata.size = heap_r - SIZE_W'(ffha_pkg::HEADER_BYTES);
        state_nxt          = ffha_pkg::S_IDLE;
      end
      ffha_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cur_nxt = '0;
          if (in_op == ffha_pkg::OP_ALLOC) begin
            if (in_size == '0) begin
              res_nxt   = '{status: ffha_pkg::STAT_NULL, offset: '0};
              state_nxt = ffha_pkg::S_RES;
            end else begin
              rsize_nxt = (RS_W'(in_size) + RS_W'(ffha_pkg::SIZE_ALIGN - 1))
                          & ~RS_W'(ffha_pkg::SIZE_ALIGN - 1);
              mem_req.re    = 1'b1;
              mem_req.raddr = '0;
              state_nxt     = ffha_pkg::S_A_CHK;
            end
          end else begin
            if (in_off < OFF_W'(ffha_pkg::HEADER_BYTES)) begin
              res_nxt   = '{status: ffha_pkg::STAT_NULL, offset: '0};
              state_nxt = ffha_pkg::S_RES;
            end else begin
              target_nxt    = in_off - OFF_W'(ffha_pkg::HEADER_BYTES);
              mem_req.re    = 1'b1;
              mem_req.raddr = '0;
              state_nxt     = ffha_pkg::S_F_CHK;
            end
          end
        end
      end
      ffha_pkg::S_A_CHK: begin
        if (fit) begin
          res_nxt = '{status: ffha_pkg::STAT_DONE,
                      offset: cur_r + OFF_W'(ffha_pkg::HEADER_BYTES)};
          mem_req.we = 1'b1;
          if (split_ok) begin
            // remainder header first, then the granted block
            mem_req.waddr      = ffha_pkg::addr_of(split_off[OFF_W-1:0]);
            mem_req.wdata.used = 1'b0;
            mem_req.wdata.next = mem_rd.next;
            mem_req.wdata.size = mem_rd.size - rsize_r[SIZE_W-1:0]
                                 - SIZE_W'(ffha_pkg::HEADER_BYTES);
            hdr_nxt.used = 1'b1;
            hdr_nxt.next = split_off[OFF_W-1:0];
            hdr_nxt.size = rsize_r[SIZE_W-1:0];
            state_nxt    = ffha_pkg::S_A_WR;
          end else begin
            mem_req.waddr      = ffha_pkg::addr_of(cur_r);
            mem_req.wdata.used = 1'b1;
            mem_req.wdata.next = mem_rd.next;
            mem_req.wdata.size = mem_rd.size;
            state_nxt          = ffha_pkg::S_RES;
          end
        end else if (mem_rd.next == '0) begin
          res_nxt   = '{status: ffha_pkg::STAT_NOFIT, offset: '0};
          state_nxt = ffha_pkg::S_RES;
        end else begin
          cur_nxt       = mem_rd.next;
          mem_req.re    = 1'b1;
          mem_req.raddr = ffha_pkg::addr_of(mem_rd.next);
        end
      end
      ffha_pkg::S_A_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ffha_pkg::addr_of(cur_r);
        mem_req.wdata = hdr_r;
        state_nxt     = ffha_pkg::S_RES;
      end
      ffha_pkg::S_F_CHK: begin
        if (cur_r == target_r) begin
          hdr_nxt.used = 1'b0;
          hdr_nxt.next = mem_rd.next;
          hdr_nxt.size = mem_rd.size;
          if (mem_rd.next == '0) begin
            mem_req.we         = 1'b1;
            mem_req.waddr      = ffha_pkg::addr_of(cur_r);
            mem_req.wdata.used = 1'b0;
            mem_req.wdata.next = mem_rd.next;
            mem_req.wdata.size = mem_rd.size;
            res_nxt   = '{status: ffha_pkg::STAT_DONE, offset: '0};
            state_nxt = ffha_pkg::S_RES;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = ffha_pkg::addr_of(mem_rd.next);
            state_nxt     = ffha_pkg::S_F_MRG;
          end
        end else if (mem_rd.next == '0) begin
          res_nxt   = '{status: ffha_pkg::STAT_NULL, offset: '0};
          state_nxt = ffha_pkg::S_RES;
        end else begin
          cur_nxt       = mem_rd.next;
          mem_req.re    = 1'b1;
          mem_req.raddr = ffha_pkg::addr_of(mem_rd.next);
        end
      end
      ffha_pkg::S_F_MRG: begin
        if (mem_rd.used) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = ffha_pkg::addr_of(cur_r);
          mem_req.wdata = hdr_r;
          res_nxt       = '{status: ffha_pkg::STAT_DONE, offset: '0};
          state_nxt     = ffha_pkg::S_RES;
        end else if (mem_rd.next == '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = ffha_pkg::addr_of(cur_r);
          mem_req.wdata = merged;
          res_nxt       = '{status: ffha_pkg::STAT_DONE, offset: '0};
          state_nxt     = ffha_pkg::S_RES;
        end else begin
          hdr_nxt       = merged;
          mem_req.re    = 1'b1;
          mem_req.raddr = ffha_pkg::addr_of(mem_rd.next);
        end
      end
      ffha_pkg::S_RES: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ffha_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ffha_pkg::S_INIT;
      end
    endcase

    if (cfg_wr_en) begin
      heap_nxt  = clamped;
      state_nxt = ffha_pkg::S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffha_pkg::S_INIT;
      heap_r  <= SIZE_W'(ffha_pkg::REGION_RESET);
    end else begin
      state_r <= state_nxt;
      heap_r  <= heap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    target_r <= target_nxt;
    rsize_r  <= rsize_nxt;
    hdr_r    <= hdr_nxt;
    res_r    <= res_nxt;
  end

  assign res = res_r;

endmodule

`default_nettype wire

FILE: design/ffha_out_reg.sv
// ----------------------------------------------------------------------------
// ffha_out_reg
// Result output register; frees the walker while a result waits downstream.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              res_valid,
  output logic                   res_ready,
  input  wire ffha_pkg::result_t res,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ffha_pkg::result_t      out_res
);

  logic              valid_r, valid_nxt;
  ffha_pkg::result_t data_r;

  always_comb begin
    res_ready = !valid_r || out_ready;
    valid_nxt = res_valid || (valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = data_r;

endmodule

`default_nettype wire

FILE: design/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a fixed heap; block headers live in a
// synchronous header memory walked one header per cycle.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in_      slave      in_tvalid / in_tready   op, request_size, free_offset
//  out_     master     out_tvalid / out_tready status, data_offset
//  cfg_     write      cfg_wr_en               heap_bytes
//
//  Alloc: S_A_CHK checks each header read and fetches the next until one fits;
//  a split adds S_A_WR. Free: S_F_CHK walks the chain, then S_F_MRG reads the
//  freed block's successors while merging (each merged neighbor and a used one that ends it).
//  The header memory read port, one header per cycle, sets the rate.
//  Reset and every heap_bytes write pass through S_INIT to rewrite header 0.
//  A stalled result sits in the output register; the next item is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [14:0] cfg_wr_data,  // heap_bytes
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,     // request_size[15:0], free_offset[29:16]
  input  wire logic [0:0]  in_tuser,     // op[0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,    // data_offset[13:0]
  output logic [1:0]       out_tuser     // status[1:0]
);

  localparam int OFF_W = ffha_pkg::OFF_W;
  localparam int REQ_W = ffha_pkg::REQ_W;

  ffha_pkg::mem_req_t mem_req;
  ffha_pkg::hdr_t     mem_rd;
  ffha_pkg::result_t  res;
  ffha_pkg::result_t  out_res;
  logic               res_valid;
  logic               res_ready;

  ffha_hdr_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd)
  );

  ffha_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (ffha_pkg::op_t'(in_tuser[0])),
    .in_size     (in_tdata[REQ_W-1:0]),
    .in_off      (in_tdata[REQ_W+OFF_W-1:REQ_W]),
    .mem_req     (mem_req),
    .mem_rd      (mem_rd),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  ffha_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {{(16-OFF_W){1'b0}}, out_res.offset};
  assign out_tuser = out_res.status;

endmodule

`default_nettype wire

FILE: design/ffha_checker.sv
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        cfg_wr_en,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("item taken before header 0 rewritten after reset");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> !in_tready)
    else $error("item taken before header 0 rewritten after config");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ffha_pkg::STAT_DONE) |-> out_tdata == '0)
    else $error("nonzero offset on failed item");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_wr_en  (cfg_wr_en),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit heap allocator. A shadow copy of the
// header chain predicts status and payload offset for every accepted item;
// results are checked in order. Directed cases, region size limits, a long
// output stall and random alloc/free traffic over several region sizes.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int SIZE_W = ffha_pkg::SIZE_W;
  localparam int OFF_W  = ffha_pkg::OFF_W;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [14:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;

  // shadow header chain, indexed by block start offset
  bit [SIZE_W-1:0] blk_size [ffha_pkg::HEAP_BYTES];
  bit [OFF_W-1:0]  blk_next [ffha_pkg::HEAP_BYTES];
  bit              blk_used [ffha_pkg::HEAP_BYTES];
  int unsigned     region_bytes;

  ffha_pkg::result_t awaited_results[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned rx_stall_cycles = 0;

  always #6 clk = ~clk;

  first_fit_heap_allocator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  function automatic void shadow_init();
    blk_size[0] = SIZE_W'(region_bytes - ffha_pkg::HEADER_BYTES);
    blk_used[0] = 1'b0;
    blk_next[0] = '0;
  endfunction

  function automatic int unsigned clamp_region(input bit [14:0] v);
    if (v < ffha_pkg::REGION_MIN) return ffha_pkg::REGION_MIN;
    if (v > ffha_pkg::HEAP_BYTES) return ffha_pkg::HEAP_BYTES;
    return 32'(v);
  endfunction

  function automatic ffha_pkg::result_t alloc_first_fit(input bit [15:0] req);
    ffha_pkg::result_t res;
    int unsigned       need, b, s, hops;
    res.status = ffha_pkg::STAT_NOFIT;
    res.offset = '0;
    if (req == 0) begin
      res.status = ffha_pkg::STAT_NULL;
      return res;
    end
    need = (32'(req) + 32'd7) & ~32'd7;
    b = 0;
    hops = 0;
    while (hops < ffha_pkg::HEAP_BYTES) begin
      if (!blk_used[b] && blk_size[b] >= need) begin
        s = b + ffha_pkg::HEADER_BYTES + need;
        if (blk_size[b] >= need + ffha_pkg::HEADER_BYTES + ffha_pkg::MIN_SPLIT_PAYLOAD
            && s < ffha_pkg::HEAP_BYTES) begin
          blk_size[s] = SIZE_W'(blk_size[b] - need - ffha_pkg::HEADER_BYTES);
          blk_used[s] = 1'b0;
          blk_next[s] = blk_next[b];
          blk_next[b] = OFF_W'(s);
          blk_size[b] = SIZE_W'(need);
        end
        blk_used[b] = 1'b1;
        res.status = ffha_pkg::STAT_DONE;
        res.offset = OFF_W'(b + ffha_pkg::HEADER_BYTES);
        return res;
      end
      if (blk_next[b] == 0) break;
      b = 32'(blk_next[b]);
      hops++;
    end
    return res;
  endfunction

  function automatic ffha_pkg::result_t release_block(input bit [13:0] off);
    ffha_pkg::result_t res;
    int unsigned       target, b, n, hops;
    res.status = ffha_pkg::STAT_NULL;
    res.offset = '0;
    if (off < ffha_pkg::HEADER_BYTES) return res;
    target = 32'(off) - ffha_pkg::HEADER_BYTES;
    b = 0;
    hops = 0;
    while (b != target) begin
      if (blk_next[b] == 0 || hops >= ffha_pkg::HEAP_BYTES) return res;
      b = 32'(blk_next[b]);
      hops++;
    end
    blk_used[b] = 1'b0;
    while (1'b1) begin
      n = 32'(blk_next[b]);
      if (n == 0 || blk_used[n]) break;
      blk_size[b] = SIZE_W'(blk_size[b] + ffha_pkg::HEADER_BYTES + blk_size[n]);
      blk_next[b] = blk_next[n];
    end
    res.status = ffha_pkg::STAT_DONE;
    return res;
  endfunction

  // one item: random gaps, then hold until accepted; predicts on acceptance
  task automatic send_item(input ffha_pkg::op_t op, input bit [15:0] req,
                           input bit [13:0] off, output ffha_pkg::result_t res);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, off, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == ffha_pkg::OP_ALLOC) res = alloc_first_fit(req);
    else res = release_block(off);
    awaited_results.push_back(res);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic region_write(input bit [14:0] v);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    region_bytes = clamp_region(v);
    shadow_init();
  endtask

  // result checker
  always @(posedge clk) begin
    ffha_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected item: status %0d data_offset %0d", out_tuser, out_tdata);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          mismatches++;
        end
        if (out_tdata !== 16'(want.offset)) begin
          $error("data_offset: expected %0d, got %0d", want.offset, out_tdata);
          mismatches++;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (rx_stall_cycles > 0) begin
      out_tready <= 1'b0;
      rx_stall_cycles = rx_stall_cycles - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_directed_cases();
    ffha_pkg::result_t r;
    snd_idle_pct = 36;
    rcv_idle_pct = 57;
    send_item(ffha_pkg::OP_ALLOC, 16'd0, 14'd0, r);        // size zero
    send_item(ffha_pkg::OP_FREE, 16'd0, 14'd0, r);         // null free
    send_item(ffha_pkg::OP_FREE, 16'd0, 14'd11, r);        // below first payload
    send_item(ffha_pkg::OP_ALLOC, 16'd1, 14'd0, r);
    send_item(ffha_pkg::OP_ALLOC, 16'hFFFF, 14'h3FFF, r);  // cannot fit
    send_item(ffha_pkg::OP_ALLOC, 16'd8, 14'd0, r);
    send_item(ffha_pkg::OP_FREE, 16'd0, 14'd100, r);       // not a block start
    send_item(ffha_pkg::OP_FREE, 16'd0, 14'd12, r);
    send_item(ffha_pkg::OP_FREE, 16'd0, 14'd12, r);        // double free
    send_item(ffha_pkg::OP_ALLOC, 16'd13, 14'd0, r);
    send_item(ffha_pkg::OP_FREE, 16'd0, 14'd32, r);
    send_item(ffha_pkg::OP_FREE, 16'd0, 14'd12, r);        // merges forward
    send_item(ffha_pkg::OP_ALLOC, 16'd28, 14'd0, r);
    send_item(ffha_pkg::OP_FREE, 16'hFFFF, 14'h3FFF, r);
    send_item(ffha_pkg::OP_ALLOC, 16'd4000, 14'd0, r);
    send_item(ffha_pkg::OP_ALLOC, 16'd4000, 14'd0, r);     // no free block large enough
    send_item(ffha_pkg::OP_ALLOC, 16'd17, 14'd0, r);
    wait_drained();
  endtask

  task automatic test_region_limits();
    ffha_pkg::result_t r;
    snd_idle_pct = 36;
    rcv_idle_pct = 57;
    region_write(15'd0);                                    // clamps to the minimum
    send_item(ffha_pkg::OP_ALLOC, 16'd52, 14'd0, r);       // rounds up to 56, larger than the region payload
    send_item(ffha_pkg::OP_ALLOC, 16'd1, 14'd0, r);
    send_item(ffha_pkg::OP_FREE, 16'd0, 14'd12, r);
    send_item(ffha_pkg::OP_ALLOC, 16'd33, 14'd0, r);       // remainder too small to split
    send_item(ffha_pkg::OP_ALLOC, 16'd1, 14'd0, r);
    send_item(ffha_pkg::OP_FREE, 16'd0, 14'd12, r);
    send_item(ffha_pkg::OP_ALLOC, 16'd20, 14'd0, r);
    send_item(ffha_pkg::OP_ALLOC, 16'd16, 14'd0, r);
    send_item(ffha_pkg::OP_FREE, 16'd0, 14'd12, r);
    send_item(ffha_pkg::OP_FREE, 16'd0, 14'd48, r);
    send_item(ffha_pkg::OP_ALLOC, 16'd52, 14'd0, r);       // fragmented
    send_item(ffha_pkg::OP_FREE, 16'd0, 14'd12, r);
    send_item(ffha_pkg::OP_ALLOC, 16'd52, 14'd0, r);
    region_write(15'h7FFF);                                 // clamps to the maximum
    send_item(ffha_pkg::OP_ALLOC, 16'd16372, 14'd0, r);
    send_item(ffha_pkg::OP_ALLOC, 16'd1, 14'd0, r);
    send_item(ffha_pkg::OP_FREE, 16'd0, 14'd12, r);
    region_write(15'd4096);
  endtask

  task automatic test_output_stall();
    ffha_pkg::result_t r;
    bit [13:0]         held[$];
    int unsigned       i;
    wait_drained();
    snd_idle_pct = 36;
    rcv_idle_pct = 57;
    @(posedge clk);
    rx_stall_cycles = 400;
    for (i = 0; i < 20; i++) begin
      if (i % 3 == 2 && held.size() != 0) begin
        send_item(ffha_pkg::OP_FREE, 16'($urandom), held.pop_front(), r);
      end else begin
        send_item(ffha_pkg::OP_ALLOC, 16'($urandom_range(1, 64)), 14'($urandom), r);
        if (r.status == ffha_pkg::STAT_DONE) held.push_back(r.offset);
      end
    end
    wait_drained();
  endtask

  task automatic run_random(input int unsigned n_items, input int unsigned max_live);
    ffha_pkg::result_t r;
    bit [13:0]         live[$];
    bit [13:0]         released[$];
    bit [13:0]         off;
    int unsigned       i, pick, idx;
    for (i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (live.size() != 0 && (pick < 40 || live.size() >= max_live)) begin
        idx = $urandom_range(live.size() - 1);
        off = live[idx];
        live.delete(idx);
        send_item(ffha_pkg::OP_FREE, 16'($urandom), off, r);
        released.push_back(off);
        if (released.size() > 16) void'(released.pop_front());
      end else if (pick < 44 && released.size() != 0) begin
        idx = $urandom_range(released.size() - 1);
        send_item(ffha_pkg::OP_FREE, 16'($urandom), released[idx], r);
      end else if (pick < 48) begin
        off = ($urandom_range(3) == 0) ? 14'd0 : 14'($urandom);
        send_item(ffha_pkg::OP_FREE, 16'($urandom), off, r);
      end else if (pick < 50) begin
        send_item(ffha_pkg::OP_ALLOC, ($urandom_range(1) != 0) ? 16'd0 : 16'($urandom),
                  14'($urandom), r);
      end else begin
        if ($urandom_range(9) == 0)
          send_item(ffha_pkg::OP_ALLOC, 16'($urandom_range(1, region_bytes)),
                    14'($urandom), r);
        else
          send_item(ffha_pkg::OP_ALLOC, 16'($urandom_range(1, 64)), 14'($urandom), r);
        if (r.status == ffha_pkg::STAT_DONE) live.push_back(r.offset);
      end
    end
  endtask

  task automatic test_random_traffic();
    snd_idle_pct = 36;
    rcv_idle_pct = 57;
    run_random(630, 40);
    region_write(15'($urandom_range(64, 1024)));
    snd_idle_pct = 57;
    rcv_idle_pct = 36;
    run_random(630, 24);
    region_write(15'($urandom));
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random(630, 48);
    wait_drained();
  endtask

  initial begin
    region_bytes = ffha_pkg::REGION_RESET;
    shadow_init();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_region_limits();
    test_output_stall();
    test_random_traffic();

    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
design/ffha_pkg.sv
design/ffha_hdr_mem.sv
design/ffha_ctrl.sv
design/ffha_out_reg.sv
design/first_fit_heap_allocator.sv
design/ffha_checker.sv
tb/tb.sv
